### rtl/snmp_response_value_extractor_defines.svh
// Assertion macros shared by the SNMP response value extractor RTL.
`ifndef SNMP_RESPONSE_VALUE_EXTRACTOR_DEFINES_SVH
`define SNMP_RESPONSE_VALUE_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Check an implication on every clock edge outside reset
`define SRVE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition on every clock edge outside reset
`define SRVE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`else

`define SRVE_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define SRVE_ASSERT_ALWAYS(lbl, cond, msg)

`endif

`endif

### rtl/srve_pkg.sv
// Types, constants and codes of the SNMP response value extractor.
`default_nettype none

package srve_pkg;

  localparam int MAX_MESSAGE_BYTES = 512;
  localparam int MAX_OID_BYTES     = 16;
  localparam int POS_W             = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int OID_IDX_W         = $clog2(MAX_OID_BYTES + 1);
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 2;
  localparam int FIFO_DEPTH        = 4;
  localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);

  // BER tags
  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;
  localparam logic [7:0] TAG_OCTETS   = 8'h04;
  localparam logic [7:0] TAG_OID      = 8'h06;
  localparam logic [6:0] LEN_MASK     = 7'h7F;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OID_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OID_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OID_LENGTH = 2'd2;

  // Report status codes
  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_BAD_TAG   = 3'd1;
  localparam logic [2:0] ST_EARLY_END = 3'd2;
  localparam logic [2:0] ST_MISMATCH  = 3'd3;
  localparam logic [2:0] ST_CUT_SHORT = 3'd4;

  // Result kinds
  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [3:0] {
    PH_OUTER, PH_VERSION, PH_COMMUNITY, PH_PDU, PH_INTS,
    PH_VBLIST, PH_VB, PH_OID, PH_VALUE, PH_DONE, PH_FAIL
  } phase_t;

  typedef enum logic [1:0] {
    SUB_TAG, SUB_LEN1, SUB_LENN, SUB_BODY
  } sub_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  value_byte;
    logic [8:0]  value_offset;
    logic [2:0]  status;
    logic [7:0]  value_tag;
    logic [31:0] value_length;
    logic [63:0] value_word;
    logic        final_res;
  } out_item_t;

  // Results produced by one parsed byte
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

endpackage

`default_nettype wire

### rtl/srve_parser.sv
// BER walker: configuration registers, parse state and per-byte result build.
`default_nettype none

module srve_parser
  import srve_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  go,
  input  wire in_item_t              item,
  output push_t                      push,
  output out_item_t                  res0,
  output out_item_t                  res1
);

  logic [63:0]          oid_low_r;
  logic [63:0]          oid_high_r;
  logic [4:0]           oid_len_r;

  phase_t               phase_r, phase_nxt;
  sub_t                 sub_r, sub_nxt;
  logic [1:0]           ints_r, ints_nxt;
  logic [31:0]          lacc_r, lacc_nxt;
  logic [6:0]           lleft_r, lleft_nxt;
  logic [31:0]          skip_r, skip_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [OID_IDX_W-1:0] idx_r, idx_nxt;
  logic                 match_r, match_nxt;
  logic [7:0]           ctag_r, ctag_nxt;
  logic [31:0]          clen_r, clen_nxt;
  logic [POS_W-1:0]     seen_r, seen_nxt;
  logic [63:0]          vacc_r, vacc_nxt;

  logic [15:0][7:0]     tgt;
  logic [7:0]           b;

  assign tgt = {oid_high_r, oid_low_r};
  assign b   = item.data_byte;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oid_low_r  <= '0;
      oid_high_r <= '0;
      oid_len_r  <= 5'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OID_LOW:    oid_low_r  <= cfg_wdata;
        REG_OID_HIGH:   oid_high_r <= cfg_wdata;
        REG_OID_LENGTH: oid_len_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Walk one byte through the BER layout and build its results
  always_comb begin
    logic        do_len;
    logic        do_skip_end;
    logic [31:0] len_val;
    logic [2:0]  st;

    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    ints_nxt  = ints_r;
    lacc_nxt  = lacc_r;
    lleft_nxt = lleft_r;
    skip_nxt  = skip_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    match_nxt = match_r;
    ctag_nxt  = ctag_r;
    clen_nxt  = clen_r;
    seen_nxt  = seen_r;
    vacc_nxt  = vacc_r;
    push      = '0;
    res0      = '0;
    res1      = '0;
    do_len      = 1'b0;
    do_skip_end = 1'b0;
    len_val     = '0;
    st          = ST_EARLY_END;

    if (go) begin
      if (pos_r < POS_W'(MAX_MESSAGE_BYTES)) begin
        pos_nxt = pos_r + 1'b1;
        if (phase_r != PH_DONE && phase_r != PH_FAIL) begin
          unique case (sub_r)
            SUB_TAG: begin
              priority if ((phase_r == PH_OUTER || phase_r == PH_VBLIST ||
                            phase_r == PH_VB) && b != TAG_SEQUENCE) begin
                phase_nxt = PH_FAIL;
              end else if ((phase_r == PH_VERSION || phase_r == PH_INTS) &&
                           b != TAG_INTEGER) begin
                phase_nxt = PH_FAIL;
              end else if (phase_r == PH_COMMUNITY && b != TAG_OCTETS) begin
                phase_nxt = PH_FAIL;
              end else if (phase_r == PH_OID && b != TAG_OID) begin
                phase_nxt = PH_FAIL;
              end else begin
                if (phase_r == PH_VALUE) begin
                  ctag_nxt = b;
                end
                sub_nxt = SUB_LEN1;
              end
            end
            SUB_LEN1: begin
              if (!b[7]) begin
                do_len  = 1'b1;
                len_val = {24'd0, b};
              end else begin
                lleft_nxt = b[6:0] & LEN_MASK;
                lacc_nxt  = '0;
                if (b[6:0] == 7'd0) begin
                  do_len = 1'b1;
                end else begin
                  sub_nxt = SUB_LENN;
                end
              end
            end
            SUB_LENN: begin
              lacc_nxt  = {lacc_r[23:0], b};
              lleft_nxt = lleft_r - 1'b1;
              if (lleft_r == 7'd1) begin
                do_len  = 1'b1;
                len_val = lacc_nxt;
              end
            end
            SUB_BODY: begin
              if (phase_r == PH_VALUE) begin
                if (match_r) begin
                  push.push0         = 1'b1;
                  res0.item_kind     = KIND_VALUE;
                  res0.value_byte    = b;
                  res0.value_offset  = seen_r[8:0];
                  vacc_nxt           = {vacc_r[55:0], b};
                end
                seen_nxt = seen_r + 1'b1;
                if ({{(32-POS_W){1'b0}}, seen_nxt} >= clen_r) begin
                  phase_nxt = PH_DONE;
                end
              end else if (phase_r == PH_OID) begin
                if (idx_r >= OID_IDX_W'(MAX_OID_BYTES) || tgt[idx_r[3:0]] != b) begin
                  match_nxt = 1'b0;
                end
                if (idx_r != OID_IDX_W'(MAX_OID_BYTES)) begin
                  idx_nxt = idx_r + 1'b1;
                end
                skip_nxt = skip_r - 1'b1;
                if (skip_r == 32'd1) begin
                  phase_nxt = PH_VALUE;
                  sub_nxt   = SUB_TAG;
                end
              end else begin
                skip_nxt = skip_r - 1'b1;
                if (skip_r == 32'd1) begin
                  do_skip_end = 1'b1;
                end
              end
            end
          endcase

          // Act on a completed length
          if (do_len) begin
            unique case (phase_r)
              PH_OUTER: begin
                phase_nxt = PH_VERSION;
                sub_nxt   = SUB_TAG;
              end
              PH_PDU: begin
                phase_nxt = PH_INTS;
                sub_nxt   = SUB_TAG;
              end
              PH_VBLIST: begin
                phase_nxt = PH_VB;
                sub_nxt   = SUB_TAG;
              end
              PH_VB: begin
                phase_nxt = PH_OID;
                sub_nxt   = SUB_TAG;
              end
              PH_VERSION, PH_COMMUNITY, PH_INTS: begin
                skip_nxt = len_val;
                if (len_val == 32'd0) begin
                  do_skip_end = 1'b1;
                end else begin
                  sub_nxt = SUB_BODY;
                end
              end
              PH_OID: begin
                idx_nxt   = '0;
                match_nxt = (len_val == {27'd0, oid_len_r});
                skip_nxt  = len_val;
                if (len_val == 32'd0) begin
                  phase_nxt = PH_VALUE;
                  sub_nxt   = SUB_TAG;
                end else begin
                  sub_nxt = SUB_BODY;
                end
              end
              default: begin
                clen_nxt = len_val;
                seen_nxt = '0;
                if (len_val == 32'd0) begin
                  phase_nxt = PH_DONE;
                end else begin
                  sub_nxt = SUB_BODY;
                end
              end
            endcase
          end

          // Close a skipped element
          if (do_skip_end) begin
            sub_nxt = SUB_TAG;
            priority if (phase_r == PH_INTS) begin
              ints_nxt = ints_r + 1'b1;
              if (ints_r == 2'd2) begin
                phase_nxt = PH_VBLIST;
              end
            end else if (phase_r == PH_VERSION) begin
              phase_nxt = PH_COMMUNITY;
            end else begin
              phase_nxt = PH_PDU;
            end
          end
        end
      end

      // Report on the final byte, then clear the parse state
      if (item.end_of_message) begin
        priority if (phase_nxt == PH_FAIL) begin
          st = ST_BAD_TAG;
        end else if (phase_nxt == PH_DONE) begin
          st = match_nxt ? ST_FOUND : ST_MISMATCH;
        end else if (phase_nxt == PH_VALUE && sub_nxt == SUB_BODY) begin
          st = match_nxt ? ST_CUT_SHORT : ST_MISMATCH;
        end else begin
          st = ST_EARLY_END;
        end
        if (push.push0) begin
          push.push1        = 1'b1;
          res1.item_kind    = KIND_REPORT;
          res1.status       = st;
          res1.value_tag    = ctag_nxt;
          res1.value_length = clen_nxt;
          res1.value_word   = match_nxt ? vacc_nxt : 64'd0;
          res1.final_res    = 1'b1;
        end else begin
          push.push0        = 1'b1;
          res0.item_kind    = KIND_REPORT;
          res0.status       = st;
          res0.value_tag    = ctag_nxt;
          res0.value_length = clen_nxt;
          res0.value_word   = match_nxt ? vacc_nxt : 64'd0;
          res0.final_res    = 1'b1;
        end
        phase_nxt = PH_OUTER;
        sub_nxt   = SUB_TAG;
        ints_nxt  = '0;
        lacc_nxt  = '0;
        lleft_nxt = '0;
        skip_nxt  = '0;
        pos_nxt   = '0;
        idx_nxt   = '0;
        match_nxt = 1'b0;
        ctag_nxt  = '0;
        clen_nxt  = '0;
        seen_nxt  = '0;
        vacc_nxt  = '0;
      end
    end
  end

  // Advance parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OUTER;
      sub_r   <= SUB_TAG;
      ints_r  <= '0;
      lacc_r  <= '0;
      lleft_r <= '0;
      skip_r  <= '0;
      pos_r   <= '0;
      idx_r   <= '0;
      match_r <= 1'b0;
      ctag_r  <= '0;
      clen_r  <= '0;
      seen_r  <= '0;
      vacc_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      sub_r   <= sub_nxt;
      ints_r  <= ints_nxt;
      lacc_r  <= lacc_nxt;
      lleft_r <= lleft_nxt;
      skip_r  <= skip_nxt;
      pos_r   <= pos_nxt;
      idx_r   <= idx_nxt;
      match_r <= match_nxt;
      ctag_r  <= ctag_nxt;
      clen_r  <= clen_nxt;
      seen_r  <= seen_nxt;
      vacc_r  <= vacc_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/srve_out_fifo.sv
// Result queue: takes up to two results a cycle, hands out one per transfer.
`default_nettype none

module srve_out_fifo
  import srve_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire push_t     push,
  input  wire out_item_t res0,
  input  wire out_item_t res1,
  output logic           room,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  out_item_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [FIFO_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;
  logic [FIFO_CNT_W-1:0] n_push;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rptr_r];
  assign pop       = out_valid && !out_stall;
  // Two free entries needed, judged on the registered count only
  assign room      = (cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign n_push    = FIFO_CNT_W'(push.push0) + FIFO_CNT_W'(push.push1);

  always_comb begin
    wptr_nxt = wptr_r + FIFO_PTR_W'(n_push);
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + n_push - FIFO_CNT_W'(pop);
  end

  // Write incoming results
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wptr_r] <= res0;
    end
    if (push.push1) begin
      mem[wptr_r + 1'b1] <= res1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/snmp_response_value_extractor.sv
// Top level of the SNMP response value extractor.
// Takes one message byte per cycle while in_stall is low and walks the BER
// layout of an SNMP response up to the first varbind; while its OID matches
// the configured target, each value byte is sent out, and the final byte of a
// message yields a report. Throughput is one byte per cycle unless stalled; a
// byte's results pass through the input register, then a four-entry result
// queue. in_stall rises while a byte is held and the queue has fewer than
// two free entries, as one byte can give a value byte and a report together.
// Write the target OID registers only while no message is in progress.
`default_nettype none

`include "snmp_response_value_extractor_defines.svh"

module snmp_response_value_extractor
  import srve_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data
);

  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      room;
  logic      go;
  push_t     push;
  out_item_t res0;
  out_item_t res1;

  // Parse the held byte once the queue has space for both results
  assign go       = s1_valid_r && room;
  assign in_stall = s1_valid_r && !room;

  // Hold the input byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  srve_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .go        (go),
    .item      (s1_data_r),
    .push      (push),
    .res0      (res0),
    .res1      (res1)
  );

  srve_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A second result only ever follows a first
  `SRVE_ASSERT_IMPLIES(a_push_order, push.push1, push.push0, "second result without first")
  // A pair is a value byte followed by the report
  `SRVE_ASSERT_IMPLIES(a_pair_kinds, push.push1,
    (res0.item_kind == KIND_VALUE && res1.item_kind == KIND_REPORT), "bad result pair")
  // Results are only built for a byte that is parsed
  `SRVE_ASSERT_IMPLIES(a_push_go, push.push0, go, "result without parsed byte")
  // Reports carry the final flag, value bytes do not
  `SRVE_ASSERT_ALWAYS(a_final_flag,
    (!out_valid || out_data.final_res == out_data.item_kind), "final flag mismatch")

endmodule

`default_nettype wire
